### rtl/sbfr_pkg.sv
// Shared constants, codes and types for the SBUS frame receiver.
package sbfr_pkg;

    localparam int FRAME_BYTES     = 25;
    localparam int ANALOG_CHANNELS = 16;
    localparam int BYTE_W          = 8;
    localparam int CHAN_BITS       = 11;
    localparam int TIME_W          = 32;
    localparam int ADDR_W          = $clog2(FRAME_BYTES);
    localparam int CHAN_IDX_W      = 5;
    localparam int STATUS_W        = 2;
    localparam int CFG_INDEX_W     = 8;
    localparam int CFG_DATA_W      = CHAN_BITS;
    localparam int FLAG_BYTE       = 23;

    // flag byte bits
    localparam int FLAG_DIG0     = 0;
    localparam int FLAG_DIG1     = 1;
    localparam int FLAG_LOST     = 2;
    localparam int FLAG_FAILSAFE = 3;

    // link status codes
    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_LOST     = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FAILSAFE = 2'd2;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_GAP_MS       = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SYNC_BYTE    = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_DIGITAL_HIGH = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_DIGITAL_LOW  = 8'd3;

    // reset values
    localparam logic [BYTE_W-1:0]    GAP_MS_RST       = 8'd5;
    localparam logic [BYTE_W-1:0]    SYNC_BYTE_RST    = 8'd15;
    localparam logic [CHAN_BITS-1:0] DIGITAL_HIGH_RST = 11'd2000;
    localparam logic [CHAN_BITS-1:0] DIGITAL_LOW_RST  = 11'd1000;

    // decode request from the byte assembler to the unpacker
    typedef struct packed {
        logic                 start;
        logic [BYTE_W-1:0]    flags;
        logic [CHAN_BITS-1:0] digital_high;
        logic [CHAN_BITS-1:0] digital_low;
    } dec_cmd_t;

endpackage

### rtl/sbfr_store.sv
// Frame byte store: one write port, one registered read port.
module sbfr_store #(
    parameter int DEPTH  = sbfr_pkg::FRAME_BYTES,
    parameter int WIDTH  = sbfr_pkg::BYTE_W,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/sbfr_unpack.sv
// Channel unpacker: bit accumulator fed one stored byte at a time, 11-bit fields out.
module sbfr_unpack (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  sbfr_pkg::dec_cmd_t                   cmd,
    output logic                                 busy,
    output logic                                 rd_en,
    output logic [sbfr_pkg::ADDR_W-1:0]          rd_addr,
    input  logic [sbfr_pkg::BYTE_W-1:0]          rd_data,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [sbfr_pkg::CHAN_IDX_W-1:0]      m_chan_index,
    output logic [sbfr_pkg::CHAN_BITS-1:0]       m_chan_value,
    output logic [sbfr_pkg::STATUS_W-1:0]        m_link_status,
    output logic                                 m_frame_last
);

    localparam int ACC_W  = sbfr_pkg::CHAN_BITS + sbfr_pkg::BYTE_W - 1;
    localparam int CNT_W  = $clog2(ACC_W + 1);
    localparam int IDX_W  = sbfr_pkg::CHAN_IDX_W;
    localparam logic [IDX_W-1:0] LAST_ANALOG = IDX_W'(sbfr_pkg::ANALOG_CHANNELS - 1);
    localparam logic [IDX_W-1:0] DIG0_CH     = IDX_W'(sbfr_pkg::ANALOG_CHANNELS);
    localparam logic [IDX_W-1:0] DIG1_CH     = IDX_W'(sbfr_pkg::ANALOG_CHANNELS + 1);
    localparam logic [CNT_W-1:0] BYTE_BITS   = CNT_W'(sbfr_pkg::BYTE_W);
    localparam logic [CNT_W-1:0] FIELD_BITS  = CNT_W'(sbfr_pkg::CHAN_BITS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_LOAD,
        ST_SEND
    } state_t;

    state_t                             state_reg;
    logic [ACC_W-1:0]                   acc_reg;
    logic [CNT_W-1:0]                   nbits_reg;
    logic [sbfr_pkg::ADDR_W-1:0]        addr_reg;
    logic [IDX_W-1:0]                   chan_reg;
    logic [1:0]                         dig_reg;
    logic                               m_valid_reg;
    logic [IDX_W-1:0]                   m_chan_index_reg;
    logic [sbfr_pkg::CHAN_BITS-1:0]     m_chan_value_reg;
    logic [sbfr_pkg::STATUS_W-1:0]      m_link_status_reg;
    logic                               m_frame_last_reg;

    logic [ACC_W-1:0]                   acc_next;
    logic [CNT_W-1:0]                   nbits_next;
    logic [IDX_W-1:0]                   chan_next;
    logic [sbfr_pkg::STATUS_W-1:0]      status_next;

    always_comb begin
        acc_next   = acc_reg | (ACC_W'(rd_data) << nbits_reg);
        nbits_next = nbits_reg + BYTE_BITS;
        chan_next  = chan_reg + IDX_W'(1);
        if (cmd.flags[sbfr_pkg::FLAG_FAILSAFE]) begin
            status_next = sbfr_pkg::STATUS_FAILSAFE;
        end else if (cmd.flags[sbfr_pkg::FLAG_LOST]) begin
            status_next = sbfr_pkg::STATUS_LOST;
        end else begin
            status_next = sbfr_pkg::STATUS_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (cmd.start) begin
                        acc_reg           <= '0;
                        nbits_reg         <= '0;
                        addr_reg          <= sbfr_pkg::ADDR_W'(1);
                        chan_reg          <= '0;
                        dig_reg           <= {cmd.flags[sbfr_pkg::FLAG_DIG1],
                                              cmd.flags[sbfr_pkg::FLAG_DIG0]};
                        m_link_status_reg <= status_next;
                        state_reg         <= ST_FETCH;
                    end
                end
                ST_FETCH: begin
                    addr_reg  <= addr_reg + sbfr_pkg::ADDR_W'(1);
                    state_reg <= ST_LOAD;
                end
                ST_LOAD: begin
                    acc_reg   <= acc_next;
                    nbits_reg <= nbits_next;
                    if (nbits_next >= FIELD_BITS) begin
                        m_chan_index_reg <= chan_reg;
                        m_chan_value_reg <= acc_next[sbfr_pkg::CHAN_BITS-1:0];
                        m_frame_last_reg <= 1'b0;
                        m_valid_reg      <= 1'b1;
                        state_reg        <= ST_SEND;
                    end else begin
                        state_reg <= ST_FETCH;
                    end
                end
                ST_SEND: begin
                    if (m_ready) begin
                        chan_reg <= chan_next;
                        if (chan_reg == DIG1_CH) begin
                            m_valid_reg <= 1'b0;
                            state_reg   <= ST_IDLE;
                        end else if (chan_reg >= LAST_ANALOG) begin
                            m_chan_index_reg <= chan_next;
                            m_chan_value_reg <= (chan_next == DIG0_CH ? dig_reg[0] : dig_reg[1])
                                                ? cmd.digital_high : cmd.digital_low;
                            m_frame_last_reg <= (chan_next == DIG1_CH);
                        end else begin
                            acc_reg     <= acc_reg >> sbfr_pkg::CHAN_BITS;
                            nbits_reg   <= nbits_reg - FIELD_BITS;
                            m_valid_reg <= 1'b0;
                            state_reg   <= ST_FETCH;
                        end
                    end
                end
                default: begin
                    state_reg   <= ST_IDLE;
                    m_valid_reg <= 1'b0;
                end
            endcase
        end
    end

    assign busy          = (state_reg != ST_IDLE);
    assign rd_en         = (state_reg == ST_FETCH);
    assign rd_addr       = addr_reg;
    assign m_valid       = m_valid_reg;
    assign m_chan_index  = m_chan_index_reg;
    assign m_chan_value  = m_chan_value_reg;
    assign m_link_status = m_link_status_reg;
    assign m_frame_last  = m_frame_last_reg;

endmodule

### rtl/sbfr_frame_receiver_top_note.sv
// Flag byte latch: holds the frame's flag byte as it is written to the store.
module sbfr_flag_latch (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        wr_en,
    input  logic [sbfr_pkg::ADDR_W-1:0] wr_addr,
    input  logic [sbfr_pkg::BYTE_W-1:0] wr_data,
    output logic [sbfr_pkg::BYTE_W-1:0] flags
);

    logic [sbfr_pkg::BYTE_W-1:0] flags_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flags_reg <= '0;
        end else if (wr_en && wr_addr == sbfr_pkg::ADDR_W'(sbfr_pkg::FLAG_BYTE)) begin
            flags_reg <= wr_data;
        end
    end

    assign flags = flags_reg;

endmodule

### rtl/sbus_frame_receiver.sv
// SBUS frame receiver top level: byte framing, configuration and decode control.
//
// Input channel (s_valid/s_ready): one received byte with its millisecond
// timestamp per item. A gap of gap_ms or more since the previous byte restarts
// the frame; at frame position 0 only sync_byte is kept. Ordinary bytes are
// taken one per cycle.
// The 25th byte of a frame starts the decode: s_ready drops and 18 channel
// items leave on m_valid/m_ready, channel 0 first, the last one flagged by
// m_frame_last. A shared 18-bit accumulator is fed one stored byte at a time,
// each read in the FETCH state and added in the LOAD state (registered store
// read), and gives up one 11-bit field at a time. A stalled receiver holds
// the current item and the decode waits; no input is taken until the last
// item is delivered.
// Configuration (cfg_valid/cfg_ready) is always ready; indexes 0..3 select
// gap_ms, sync_byte, digital_high, digital_low, others are ignored.
// Reset restores the register defaults and the frame position; the store
// itself is not cleared.
module sbus_frame_receiver (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [sbfr_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [sbfr_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [sbfr_pkg::BYTE_W-1:0]          s_rx_byte,
    input  logic [sbfr_pkg::TIME_W-1:0]          s_now_ms,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [sbfr_pkg::CHAN_IDX_W-1:0]      m_chan_index,
    output logic [sbfr_pkg::CHAN_BITS-1:0]       m_chan_value,
    output logic [sbfr_pkg::STATUS_W-1:0]        m_link_status,
    output logic                                 m_frame_last
);

    localparam int AW = sbfr_pkg::ADDR_W;
    localparam logic [AW-1:0] LAST_POS = AW'(sbfr_pkg::FRAME_BYTES - 1);

    logic [sbfr_pkg::BYTE_W-1:0]    gap_ms_reg;
    logic [sbfr_pkg::BYTE_W-1:0]    sync_byte_reg;
    logic [sbfr_pkg::CHAN_BITS-1:0] digital_high_reg;
    logic [sbfr_pkg::CHAN_BITS-1:0] digital_low_reg;
    logic [AW-1:0]                  pos_reg;
    logic [sbfr_pkg::TIME_W-1:0]    last_time_reg;

    logic                           s_fire;
    logic [sbfr_pkg::TIME_W-1:0]    elapsed;
    logic [AW-1:0]                  pos_eff;
    logic                           drop;
    logic                           wr_en;
    logic                           frame_done;
    logic                           busy;
    logic                           rd_en;
    logic [AW-1:0]                  rd_addr;
    logic [sbfr_pkg::BYTE_W-1:0]    rd_data;
    logic [sbfr_pkg::BYTE_W-1:0]    flags;
    sbfr_pkg::dec_cmd_t             cmd;

    assign cfg_ready = 1'b1;
    assign s_ready   = !busy;
    assign s_fire    = s_valid && s_ready;

    always_comb begin
        elapsed    = s_now_ms - last_time_reg;
        pos_eff    = (elapsed >= sbfr_pkg::TIME_W'(gap_ms_reg)) ? '0 : pos_reg;
        drop       = (pos_eff == '0) && (s_rx_byte != sync_byte_reg);
        wr_en      = s_fire && !drop;
        frame_done = wr_en && (pos_eff == LAST_POS);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gap_ms_reg       <= sbfr_pkg::GAP_MS_RST;
            sync_byte_reg    <= sbfr_pkg::SYNC_BYTE_RST;
            digital_high_reg <= sbfr_pkg::DIGITAL_HIGH_RST;
            digital_low_reg  <= sbfr_pkg::DIGITAL_LOW_RST;
            pos_reg          <= '0;
            last_time_reg    <= '0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    sbfr_pkg::REG_GAP_MS:       gap_ms_reg <= cfg_data[sbfr_pkg::BYTE_W-1:0];
                    sbfr_pkg::REG_SYNC_BYTE:    sync_byte_reg <= cfg_data[sbfr_pkg::BYTE_W-1:0];
                    sbfr_pkg::REG_DIGITAL_HIGH: digital_high_reg <= cfg_data;
                    sbfr_pkg::REG_DIGITAL_LOW:  digital_low_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (s_fire) begin
                last_time_reg <= s_now_ms;
                if (drop || frame_done) begin
                    pos_reg <= '0;
                end else begin
                    pos_reg <= pos_eff + AW'(1);
                end
            end
        end
    end

    always_comb begin
        cmd.start        = frame_done;
        cmd.flags        = flags;
        cmd.digital_high = digital_high_reg;
        cmd.digital_low  = digital_low_reg;
    end

    sbfr_store #(
        .DEPTH (sbfr_pkg::FRAME_BYTES),
        .WIDTH (sbfr_pkg::BYTE_W)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (pos_eff),
        .wr_data (s_rx_byte),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    sbfr_flag_latch u_flags (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (wr_en),
        .wr_addr (pos_eff),
        .wr_data (s_rx_byte),
        .flags   (flags)
    );

    sbfr_unpack u_unpack (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .busy          (busy),
        .rd_en         (rd_en),
        .rd_addr       (rd_addr),
        .rd_data       (rd_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_chan_index  (m_chan_index),
        .m_chan_value  (m_chan_value),
        .m_link_status (m_link_status),
        .m_frame_last  (m_frame_last)
    );

endmodule

### test/sbus_frame_receiver_tb.sv
// Self-checking testbench for sbus_frame_receiver: random framed byte traffic, checked per channel item.
`timescale 1ns / 100ps

module sbus_frame_receiver_tb;
    import sbfr_pkg::*;

    typedef struct packed {
        logic [BYTE_W-1:0] rx;
        logic [TIME_W-1:0] stamp;
    } rx_item_t;

    typedef struct packed {
        logic [CHAN_IDX_W-1:0] idx;
        logic [CHAN_BITS-1:0]  value;
        logic [STATUS_W-1:0]   status;
        logic                  last;
    } chan_item_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic [BYTE_W-1:0]      s_rx_byte = '0;
    logic [TIME_W-1:0]      s_now_ms = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [CHAN_IDX_W-1:0]  m_chan_index;
    logic [CHAN_BITS-1:0]   m_chan_value;
    logic [STATUS_W-1:0]    m_link_status;
    logic                   m_frame_last;

    sbus_frame_receiver u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_rx_byte     (s_rx_byte),
        .s_now_ms      (s_now_ms),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_chan_index  (m_chan_index),
        .m_chan_value  (m_chan_value),
        .m_link_status (m_link_status),
        .m_frame_last  (m_frame_last)
    );

    always #1 aclk = ~aclk;

    // predictor state
    logic [BYTE_W-1:0]    cur_gap_ms   = GAP_MS_RST;
    logic [BYTE_W-1:0]    cur_start    = SYNC_BYTE_RST;
    logic [CHAN_BITS-1:0] cur_dig_high = DIGITAL_HIGH_RST;
    logic [CHAN_BITS-1:0] cur_dig_low  = DIGITAL_LOW_RST;
    logic [BYTE_W-1:0]    frame_buf [FRAME_BYTES];
    int                   buf_pos = 0;
    logic [TIME_W-1:0]    prev_stamp = '0;

    rx_item_t   byte_q[$];
    chan_item_t chan_due_q[$];
    int         n_queued = 0;
    int         n_taken = 0;
    int         n_made = 0;
    int         errors = 0;
    logic [TIME_W-1:0] gen_stamp = '0;

    task automatic report_mismatch(string what);
        $display("ERROR @%0t: %s", $time, what);
        errors++;
    endtask

    function automatic void decode_byte(logic [BYTE_W-1:0] b, logic [TIME_W-1:0] stamp);
        logic [TIME_W-1:0]    dt;
        logic [175:0]         payload;
        logic [BYTE_W-1:0]    flags;
        logic [STATUS_W-1:0]  st;
        chan_item_t           e;
        dt = stamp - prev_stamp;
        if (dt >= TIME_W'(cur_gap_ms)) buf_pos = 0;
        prev_stamp = stamp;
        if (buf_pos >= FRAME_BYTES) buf_pos = 0;
        if (buf_pos == 0 && b != cur_start) return;
        frame_buf[buf_pos] = b;
        buf_pos++;
        if (buf_pos != FRAME_BYTES) return;
        buf_pos = 0;
        for (int k = 1; k <= 22; k++) payload[8*(k-1) +: 8] = frame_buf[k];
        flags = frame_buf[FLAG_BYTE];
        st = STATUS_OK;
        if (flags[FLAG_LOST]) st = STATUS_LOST;
        if (flags[FLAG_FAILSAFE]) st = STATUS_FAILSAFE;
        for (int ch = 0; ch < ANALOG_CHANNELS + 2; ch++) begin
            e.idx    = CHAN_IDX_W'(ch);
            e.status = st;
            e.last   = (ch == ANALOG_CHANNELS + 1);
            if (ch < ANALOG_CHANNELS)
                e.value = payload[ch*CHAN_BITS +: CHAN_BITS];
            else if (ch == ANALOG_CHANNELS)
                e.value = flags[FLAG_DIG0] ? cur_dig_high : cur_dig_low;
            else
                e.value = flags[FLAG_DIG1] ? cur_dig_high : cur_dig_low;
            chan_due_q.push_back(e);
        end
    endfunction

    // byte driver: bursts with random gaps
    int burst_left = 0;
    int idle_left = 0;

    always @(posedge aclk) begin : drive
        rx_item_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                decode_byte(s_rx_byte, s_now_ms);
                n_taken++;
            end
            if (!s_valid || s_ready) begin
                if (idle_left != 0) begin
                    idle_left--;
                    s_valid <= 1'b0;
                end else if (byte_q.size() != 0) begin
                    nxt = byte_q.pop_front();
                    s_valid   <= 1'b1;
                    s_rx_byte <= nxt.rx;
                    s_now_ms  <= nxt.stamp;
                    if (burst_left == 0) burst_left = $urandom_range(1, 40);
                    burst_left--;
                    if (burst_left == 0)
                        idle_left = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 60)
                                                                : $urandom_range(0, 4);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // channel monitor and receiver stall pattern
    int rdy_left = 0;

    always @(posedge aclk) begin : watch
        chan_item_t got, want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                got = '{m_chan_index, m_chan_value, m_link_status, m_frame_last};
                if (chan_due_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected channel item idx %0d val %0d",
                                              got.idx, got.value));
                end else begin
                    want = chan_due_q.pop_front();
                    if (got.idx !== want.idx || got.value !== want.value ||
                        got.status !== want.status || got.last !== want.last)
                        report_mismatch($sformatf(
                            "got idx %0d val %0d st %0d last %0d, want %0d %0d %0d %0d",
                            got.idx, got.value, got.status, got.last,
                            want.idx, want.value, want.status, want.last));
                end
            end
            if (rdy_left == 0) begin
                if (m_ready) begin
                    rdy_left = $urandom_range(1, 12);
                    m_ready <= 1'b0;
                end else begin
                    rdy_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                                           : $urandom_range(1, 8);
                    m_ready <= 1'b1;
                end
            end else begin
                rdy_left--;
            end
        end
    end

    task automatic cfg_write(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_GAP_MS:       cur_gap_ms   = data[BYTE_W-1:0];
            REG_SYNC_BYTE:    cur_start    = data[BYTE_W-1:0];
            REG_DIGITAL_HIGH: cur_dig_high = data;
            REG_DIGITAL_LOW:  cur_dig_low  = data;
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic push_byte(logic [BYTE_W-1:0] b, logic [TIME_W-1:0] stamp);
        byte_q.push_back('{b, stamp});
        n_queued++;
        n_made++;
    endtask

    // fill: 0 random content, 1 all zero, 2 all ones
    task automatic add_frame(int n, int fill);
        logic [BYTE_W-1:0] b;
        gen_stamp += cur_gap_ms + (($urandom_range(0, 1) == 0) ? 0 :
                     ($urandom_range(0, 7) == 0) ? $urandom_range(0, 32'hFFFF_0000)
                                                 : $urandom_range(0, 500));
        push_byte(cur_start, gen_stamp);
        for (int p = 1; p < n; p++) begin
            gen_stamp += ($urandom_range(0, 3) == 0) ? cur_gap_ms - 1
                                                     : $urandom_range(0, cur_gap_ms - 1);
            b = (fill == 1) ? 8'h00 : (fill == 2) ? 8'hFF : 8'($urandom_range(0, 255));
            push_byte(b, gen_stamp);
        end
    endtask

    task automatic random_traffic(int budget);
        int r;
        n_made = 0;
        while (n_made < budget) begin
            r = $urandom_range(0, 11);
            if (r <= 7 || r == 11) begin
                add_frame(FRAME_BYTES,
                          ($urandom_range(0, 11) == 0) ? $urandom_range(1, 2) : 0);
            end else if (r == 8) begin
                add_frame($urandom_range(1, FRAME_BYTES - 1), 0);
            end else if (r == 9) begin
                repeat ($urandom_range(1, 4)) begin
                    gen_stamp = $urandom;
                    push_byte(8'($urandom_range(0, 255)), gen_stamp);
                end
            end else begin
                gen_stamp += cur_gap_ms + $urandom_range(0, 50);
                push_byte(cur_start ^ 8'($urandom_range(1, 255)), gen_stamp);
            end
        end
    endtask

    task automatic settle();
        int waited;
        waited = 0;
        do @(posedge aclk); while (n_taken != n_queued);
        while (chan_due_q.size() != 0 && waited < 20000) begin
            @(posedge aclk);
            waited++;
        end
        if (chan_due_q.size() != 0) begin
            report_mismatch($sformatf("%0d channel items never arrived", chan_due_q.size()));
            chan_due_q.delete();
        end
        repeat (100) @(posedge aclk);
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // wrong start byte at time zero, a cut-off frame, then a full-scale frame across the wrap
        push_byte(8'h00, 32'd0);
        gen_stamp = 32'd10;
        add_frame(2, 0);
        gen_stamp = 32'hFFFF_FFE0;
        add_frame(FRAME_BYTES, 2);
        random_traffic(70);
        settle();

        cfg_write(REG_GAP_MS, 11'd1);
        cfg_write(REG_SYNC_BYTE, 11'd0);
        cfg_write(REG_DIGITAL_HIGH, 11'h7FF);
        cfg_write(REG_DIGITAL_LOW, 11'd0);
        cfg_write(8'd4, 11'($urandom_range(0, 2047)));
        random_traffic(60);
        settle();

        // oversized values are cut to the register width
        cfg_write(REG_GAP_MS, 11'h7FF);
        cfg_write(REG_SYNC_BYTE, 11'h7A5);
        cfg_write(REG_DIGITAL_HIGH, 11'd0);
        cfg_write(REG_DIGITAL_LOW, 11'h7FF);
        cfg_write(8'hFF, 11'h7FF);
        random_traffic(60);
        settle();

        // zero gap: every byte restarts the frame
        cfg_write(REG_GAP_MS, 11'h100);
        repeat (10) begin
            gen_stamp += $urandom_range(0, 3);
            push_byte(($urandom_range(0, 1) == 0) ? cur_start : 8'($urandom_range(0, 255)),
                      gen_stamp);
        end
        settle();

        repeat (3) begin
            cfg_write(REG_GAP_MS, ($urandom_range(0, 3) == 0) ? 11'($urandom_range(1, 255))
                                                              : 11'($urandom_range(1, 12)));
            cfg_write(REG_SYNC_BYTE, 11'($urandom_range(0, 255)));
            cfg_write(REG_DIGITAL_HIGH, 11'($urandom_range(0, 2047)));
            cfg_write(REG_DIGITAL_LOW, 11'($urandom_range(0, 2047)));
            random_traffic(70);
            settle();
        end

        if (errors == 0)
            $display("sbus_frame_receiver: match");
        else
            $display("sbus_frame_receiver: mismatch");
        $finish;
    end

    initial begin
        #1_000_000;
        $display("sbus_frame_receiver: mismatch");
        $finish;
    end

endmodule
